// File: design/ham6_pkg.sv
// ----------------------------------------------------------------------------
// ham6_pkg
// shared types, constants and distance helpers of the ham6 pixel encoder
// ----------------------------------------------------------------------------
`default_nettype none

package ham6_pkg;

    localparam int PALETTE_SIZE_DEF = 16;
    localparam int CHAN_W           = 4;
    localparam int COLOUR_W         = 3 * CHAN_W;
    localparam int DIST_W           = 6;
    localparam int PEN_W            = 6;
    localparam int THR_W            = 6;
    localparam int SEED_W           = 64;
    localparam int CFG_IDX_W        = 3;
    localparam int REG_IDX_W        = 4;
    localparam int PLAIN_USED       = 2;
    localparam int THRESHOLD_RESET  = 4;

    // colour packing: red in the low nibble, then green, then blue
    typedef logic [COLOUR_W-1:0] colour_t;
    typedef logic [CHAN_W-1:0]   chan_val_t;
    typedef logic [DIST_W-1:0]   dist_t;

    localparam colour_t COLOUR_BLACK = '0;
    localparam colour_t COLOUR_WHITE = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_SEEDED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_RED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_GREEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_BLUE  = 3'd4;

    // ham modify codes
    localparam logic [PEN_W-1:0] MOD_RED   = 6'h20;
    localparam logic [PEN_W-1:0] MOD_GREEN = 6'h30;
    localparam logic [PEN_W-1:0] MOD_BLUE  = 6'h10;

    // one register read presented to the scan unit
    typedef struct packed {
        logic                 valid;
        logic [REG_IDX_W-1:0] idx;
    } scan_ctl_t;

    function automatic chan_val_t absdiff(input chan_val_t a, input chan_val_t b);
        return (a > b) ? chan_val_t'(a - b) : chan_val_t'(b - a);
    endfunction

    function automatic dist_t colour_dist(input colour_t a, input colour_t b);
        return dist_t'(absdiff(a[3:0], b[3:0])) + dist_t'(absdiff(a[7:4], b[7:4]))
             + dist_t'(absdiff(a[11:8], b[11:8]));
    endfunction

endpackage

`default_nettype wire

// File: design/ham6_pixel_encoder.sv
// ----------------------------------------------------------------------------
// ham6_pixel_encoder
// hold-and-modify pen chooser with a palette held in a synchronous ram
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s_       in   s_tvalid / s_tready  tdata: red, green, blue; tuser: first, start
//  m_       out  m_tvalid / m_tready  tdata: pen; tuser: new_register
//  cfg_     in   cfg_wr_en            cfg_index, cfg_data
//
//  a pixel scans the registers in use, one read per cycle on the palette ram;
//  a pixel equal to the held colour skips the scan unless it is first in line
//  start_picture adds a reload of the palette, one write per register
//  after reset a plain palette reload runs, s_tready low
//  a waiting result holds the encoder in its last step until m_tready
// ----------------------------------------------------------------------------
`default_nettype none

module ham6_pixel_encoder #(
    parameter int PALETTE_SIZE = ham6_pkg::PALETTE_SIZE_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [15:0]                       s_tdata,   // red, green, blue
    input  wire logic [1:0]                        s_tuser,   // first_in_line, start_picture
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [7:0]                             m_tdata,   // pen
    output logic [0:0]                             m_tuser,   // new_register
    input  wire logic                              cfg_wr_en,
    input  wire logic [ham6_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ham6_pkg::SEED_W-1:0]       cfg_data
);

    localparam int IDX_W = $clog2(PALETTE_SIZE);
    localparam int CNT_W = $clog2(PALETTE_SIZE + 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(PALETTE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(PALETTE_SIZE - 1);
    localparam logic [IDX_W-1:0] WHITE_IDX = IDX_W'(1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_IDLE,
        ST_CHOOSE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } chan_t;

    state_t state_reg;

    // configuration
    logic [ham6_pkg::THR_W-1:0]  threshold_reg;
    logic                        use_seeded_reg;
    logic [ham6_pkg::SEED_W-1:0] seed_red_reg;
    logic [ham6_pkg::SEED_W-1:0] seed_green_reg;
    logic [ham6_pkg::SEED_W-1:0] seed_blue_reg;

    // item and palette state
    ham6_pkg::colour_t pix_reg;
    logic              first_reg;
    logic              item_reg;
    ham6_pkg::colour_t held_reg;
    logic [CNT_W-1:0]  used_reg;
    logic [IDX_W-1:0]  load_idx_reg;
    logic [CNT_W-1:0]  issue_cnt_reg;
    logic              pend_reg;
    logic [IDX_W-1:0]  pend_idx_reg;

    logic                       m_tvalid_reg;
    logic [ham6_pkg::PEN_W-1:0] pen_reg;
    logic                       new_reg;

    // ram
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    ham6_pkg::colour_t ram_wdata;
    ham6_pkg::colour_t ram_rdata;
    ham6_pkg::colour_t load_colour;

    // scan
    ham6_pkg::scan_ctl_t            scan_ctl;
    ham6_pkg::dist_t                best_dist;
    logic [ham6_pkg::REG_IDX_W-1:0] best_idx;
    ham6_pkg::colour_t              best_colour;

    // hold distance and worst channel
    ham6_pkg::chan_val_t d_r, d_g, d_b, worst;
    chan_t               worst_ch;
    ham6_pkg::dist_t     hold_dist;
    logic                need_scan;
    logic                alloc;
    logic                use_reg;
    logic                out_free;
    ham6_pkg::chan_val_t mod_val;
    logic [ham6_pkg::PEN_W-1:0] mod_code;
    ham6_pkg::colour_t   held_mod;

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        d_r = ham6_pkg::absdiff(pix_reg[3:0], held_reg[3:0]);
        d_g = ham6_pkg::absdiff(pix_reg[7:4], held_reg[7:4]);
        d_b = ham6_pkg::absdiff(pix_reg[11:8], held_reg[11:8]);
        worst    = d_r;
        worst_ch = CH_RED;
        if (d_g > worst) begin
            worst    = d_g;
            worst_ch = CH_GREEN;
        end
        if (d_b > worst) begin
            worst    = d_b;
            worst_ch = CH_BLUE;
        end
        hold_dist = ham6_pkg::dist_t'(d_r) + ham6_pkg::dist_t'(d_g)
                  + ham6_pkg::dist_t'(d_b) - ham6_pkg::dist_t'(worst);
    end

    always_comb begin
        held_mod = held_reg;
        case (worst_ch)
            CH_GREEN: begin
                mod_val        = pix_reg[7:4];
                mod_code       = ham6_pkg::MOD_GREEN;
                held_mod[7:4]  = pix_reg[7:4];
            end
            CH_BLUE: begin
                mod_val        = pix_reg[11:8];
                mod_code       = ham6_pkg::MOD_BLUE;
                held_mod[11:8] = pix_reg[11:8];
            end
            default: begin
                mod_val        = pix_reg[3:0];
                mod_code       = ham6_pkg::MOD_RED;
                held_mod[3:0]  = pix_reg[3:0];
            end
        endcase
    end

    assign need_scan = first_reg || (hold_dist != '0);
    assign alloc     = need_scan && (best_dist > threshold_reg) && (used_reg < FULL_CNT);
    assign use_reg   = first_reg || ((hold_dist != '0) && (alloc || best_dist < hold_dist));

    always_comb begin
        if (use_seeded_reg) begin
            load_colour = {seed_blue_reg[{load_idx_reg, 2'b00} +: 4],
                           seed_green_reg[{load_idx_reg, 2'b00} +: 4],
                           seed_red_reg[{load_idx_reg, 2'b00} +: 4]};
        end else if (load_idx_reg == WHITE_IDX) begin
            load_colour = ham6_pkg::COLOUR_WHITE;
        end else begin
            load_colour = ham6_pkg::COLOUR_BLACK;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = load_idx_reg;
        ram_wdata = load_colour;
        if (state_reg == ST_LOAD) begin
            ram_we = 1'b1;
        end else if (state_reg == ST_DECIDE && out_free && alloc) begin
            ram_we    = 1'b1;
            ram_waddr = used_reg[IDX_W-1:0];
            ram_wdata = pix_reg;
        end
    end

    assign scan_ctl.valid = pend_reg;
    assign scan_ctl.idx   = ham6_pkg::REG_IDX_W'(pend_idx_reg);

    ham6_ram #(
        .WIDTH (ham6_pkg::COLOUR_W),
        .DEPTH (PALETTE_SIZE)
    ) u_palette (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    ham6_scan u_scan (
        .aclk        (aclk),
        .ctl         (scan_ctl),
        .pix         (pix_reg),
        .rdata       (ram_rdata),
        .best_dist   (best_dist),
        .best_idx    (best_idx),
        .best_colour (best_colour)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= ham6_pkg::THR_W'(ham6_pkg::THRESHOLD_RESET);
            use_seeded_reg <= 1'b0;
            seed_red_reg   <= '0;
            seed_green_reg <= '0;
            seed_blue_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ham6_pkg::REG_THRESHOLD:  threshold_reg  <= cfg_data[ham6_pkg::THR_W-1:0];
                ham6_pkg::REG_USE_SEEDED: use_seeded_reg <= cfg_data[0];
                ham6_pkg::REG_SEED_RED:   seed_red_reg   <= cfg_data;
                ham6_pkg::REG_SEED_GREEN: seed_green_reg <= cfg_data;
                ham6_pkg::REG_SEED_BLUE:  seed_blue_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            item_reg      <= 1'b0;
            held_reg      <= '0;
            used_reg      <= CNT_W'(ham6_pkg::PLAIN_USED);
            load_idx_reg  <= '0;
            issue_cnt_reg <= '0;
            pend_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (state_reg == ST_DECIDE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD: begin
                    if (load_idx_reg == LAST_IDX) begin
                        load_idx_reg <= '0;
                        used_reg     <= use_seeded_reg ? FULL_CNT
                                                       : CNT_W'(ham6_pkg::PLAIN_USED);
                        state_reg    <= item_reg ? ST_CHOOSE : ST_IDLE;
                    end else begin
                        load_idx_reg <= load_idx_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        pix_reg   <= s_tdata[ham6_pkg::COLOUR_W-1:0];
                        first_reg <= s_tuser[0];
                        item_reg  <= 1'b1;
                        state_reg <= s_tuser[1] ? ST_LOAD : ST_CHOOSE;
                    end
                end
                ST_CHOOSE: begin
                    issue_cnt_reg <= '0;
                    pend_reg      <= 1'b0;
                    state_reg     <= need_scan ? ST_SCAN : ST_DECIDE;
                end
                ST_SCAN: begin
                    if (issue_cnt_reg < used_reg) begin
                        pend_reg      <= 1'b1;
                        pend_idx_reg  <= issue_cnt_reg[IDX_W-1:0];
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                    end else begin
                        pend_reg <= 1'b0;
                        if (!pend_reg) begin
                            state_reg <= ST_DECIDE;
                        end
                    end
                end
                ST_DECIDE: begin
                    if (out_free) begin
                        item_reg     <= 1'b0;
                        state_reg    <= ST_IDLE;
                        if (use_reg) begin
                            if (alloc) begin
                                pen_reg  <= ham6_pkg::PEN_W'(used_reg);
                                held_reg <= pix_reg;
                                used_reg <= used_reg + 1'b1;
                            end else begin
                                pen_reg  <= ham6_pkg::PEN_W'(best_idx);
                                held_reg <= best_colour;
                            end
                            new_reg <= alloc;
                        end else begin
                            pen_reg  <= mod_code | ham6_pkg::PEN_W'(mod_val);
                            held_reg <= held_mod;
                            new_reg  <= 1'b0;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, pen_reg};
    assign m_tuser  = new_reg;

endmodule

`default_nettype wire

// File: design/ham6_ram.sv
// ----------------------------------------------------------------------------
// ham6_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ham6_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/ham6_scan.sv
// ----------------------------------------------------------------------------
// ham6_scan
// nearest palette register search, one register compared per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ham6_scan (
    input  wire logic                               aclk,
    input  wire ham6_pkg::scan_ctl_t                ctl,
    input  wire ham6_pkg::colour_t                  pix,
    input  wire ham6_pkg::colour_t                  rdata,
    output ham6_pkg::dist_t                         best_dist,
    output logic [ham6_pkg::REG_IDX_W-1:0]          best_idx,
    output ham6_pkg::colour_t                       best_colour
);

    ham6_pkg::dist_t d;

    ham6_pkg::dist_t                 best_dist_reg;
    logic [ham6_pkg::REG_IDX_W-1:0]  best_idx_reg;
    ham6_pkg::colour_t               best_colour_reg;

    assign d = ham6_pkg::colour_dist(pix, rdata);

    // register zero opens the search, later ones win only when strictly closer
    always_ff @(posedge aclk) begin
        if (ctl.valid && (ctl.idx == '0 || d < best_dist_reg)) begin
            best_dist_reg   <= d;
            best_idx_reg    <= ctl.idx;
            best_colour_reg <= rdata;
        end
    end

    assign best_dist   = best_dist_reg;
    assign best_idx    = best_idx_reg;
    assign best_colour = best_colour_reg;

endmodule

`default_nettype wire
